@@ hw/rtl/gclp_pkg.sv @@
// Shared types, constants and helper functions for the G-code line parser.
// Used by gclp_ctrl, gclp_dp and gcode_line_parser; depends on nothing.
`timescale 1ns / 1ps

package gclp_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int NUM_PARAMS = 11;
   localparam int MAX_FRAC   = 9;
   // divider dividend: accumulator shifted by the fraction bits, plus a carry bit
   localparam int DIV_W      = 64 + FRAC_BITS + 1;
   localparam int DCNT_W     = $clog2(DIV_W);
   localparam int P10_W      = 30;
   localparam int RSP_BITS   = 13 + 8 + 16 + 8 + 7 * 32 + 64;
   localparam int RSP_W      = ((RSP_BITS + 7) / 8) * 8;

   // field indexes, in letter order g m t s p x y z f e n
   localparam logic [3:0] F_G    = 4'd0;
   localparam logic [3:0] F_M    = 4'd1;
   localparam logic [3:0] F_T    = 4'd2;
   localparam logic [3:0] F_S    = 4'd3;
   localparam logic [3:0] F_P    = 4'd4;
   localparam logic [3:0] F_X    = 4'd5;
   localparam logic [3:0] F_Y    = 4'd6;
   localparam logic [3:0] F_Z    = 4'd7;
   localparam logic [3:0] F_F    = 4'd8;
   localparam logic [3:0] F_E    = 4'd9;
   localparam logic [3:0] F_N    = 4'd10;
   localparam logic [3:0] F_NONE = 4'd15;

   localparam int HOST_BIT  = 11;
   localparam int CHECK_BIT = 12;

   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_AT    = 8'h40;
   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_ZERO  = 8'h30;

   typedef enum logic [2:0] {
      PH_START, PH_FIELDS, PH_HOST, PH_IGNORE, PH_SEEK, PH_CHECK
   } phase_type;

   typedef enum logic [2:0] {
      ST_PRE, ST_SIGN, ST_INT, ST_DOT, ST_FRAC, ST_BAD, ST_OK
   } nstage_type;

   typedef enum logic [2:0] {
      S_IDLE, S_EXEC, S_DIV_EXEC, S_FIN, S_DIV_FIN
   } state_type;

   typedef struct packed {
      logic load;
      logic exec;
      logic div_start;
      logic div_run;
      logic fin_field;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic last;
      logic need_div_exec;
      logic need_div_fin;
      logic fin_pending;
      logic div_last;
      logic rsp_free;
   } status_type;

   function automatic logic is_blank(input logic [7:0] c);
      return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic [P10_W-1:0] pow10(input logic [3:0] n);
      logic [P10_W-1:0] r;
      case (n)
         4'd0: r = 30'd1;
         4'd1: r = 30'd10;
         4'd2: r = 30'd100;
         4'd3: r = 30'd1000;
         4'd4: r = 30'd10000;
         4'd5: r = 30'd100000;
         4'd6: r = 30'd1000000;
         4'd7: r = 30'd10000000;
         4'd8: r = 30'd100000000;
         4'd9: r = 30'd1000000000;
         default: r = 30'd1;
      endcase
      return r;
   endfunction

   function automatic logic [3:0] letter_index(input logic [7:0] lc);
      logic [3:0] r;
      case (lc)
         8'h67: r = F_G;
         8'h6D: r = F_M;
         8'h74: r = F_T;
         8'h73: r = F_S;
         8'h70: r = F_P;
         8'h78: r = F_X;
         8'h79: r = F_Y;
         8'h7A: r = F_Z;
         8'h66: r = F_F;
         8'h65: r = F_E;
         8'h6E: r = F_N;
         default: r = F_NONE;
      endcase
      return r;
   endfunction

   // saturate a magnitude with sign into the 32-bit signed range
   function automatic logic [31:0] sat_s32(input logic [63:0] mag, input logic neg);
      logic [31:0] r;
      if (neg) begin
         if (mag >= 64'h8000_0000) r = 32'h8000_0000;
         else r = 32'(~mag[31:0] + 32'd1);
      end else begin
         if (mag > 64'h7FFF_FFFF) r = 32'h7FFF_FFFF;
         else r = mag[31:0];
      end
      return r;
   endfunction

endpackage

@@ hw/rtl/gclp_ctrl.sv @@
// Sequencer of the G-code line parser: takes beats, runs the per-character
// step, the fixed-point divider and the end-of-line wrap-up. Uses gclp_pkg.
`timescale 1ns / 1ps

module gclp_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  gclp_pkg::status_type sts,
   output gclp_pkg::cmd_type    cmd
);

   gclp_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= gclp_pkg::S_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         gclp_pkg::S_IDLE: begin
            if (req_tvalid) state_in = gclp_pkg::S_EXEC;
         end
         gclp_pkg::S_EXEC: begin
            if (sts.need_div_exec) state_in = gclp_pkg::S_DIV_EXEC;
            else if (sts.last) state_in = gclp_pkg::S_FIN;
            else state_in = gclp_pkg::S_IDLE;
         end
         gclp_pkg::S_DIV_EXEC: begin
            if (sts.div_last) state_in = gclp_pkg::S_EXEC;
         end
         gclp_pkg::S_FIN: begin
            if (sts.need_div_fin) state_in = gclp_pkg::S_DIV_FIN;
            else if (!sts.fin_pending && sts.rsp_free) state_in = gclp_pkg::S_IDLE;
         end
         gclp_pkg::S_DIV_FIN: begin
            if (sts.div_last) state_in = gclp_pkg::S_FIN;
         end
         default: state_in = gclp_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_tready = 1'b0;
      case (state_ff)
         gclp_pkg::S_IDLE: begin
            req_tready = 1'b1;
            cmd.load = req_tvalid;
         end
         gclp_pkg::S_EXEC: begin
            cmd.div_start = sts.need_div_exec;
            cmd.exec = !sts.need_div_exec;
         end
         gclp_pkg::S_DIV_EXEC, gclp_pkg::S_DIV_FIN: begin
            cmd.div_run = 1'b1;
         end
         gclp_pkg::S_FIN: begin
            if (sts.need_div_fin) cmd.div_start = 1'b1;
            else if (sts.fin_pending) cmd.fin_field = 1'b1;
            else cmd.emit = sts.rsp_free;
         end
         default: cmd = '0;
      endcase
   end

endmodule

@@ hw/rtl/gclp_dp.sv @@
// Datapath of the G-code line parser: character registers, line state,
// number accumulator, bit-serial fixed-point divider, value store and the
// result register. Uses gclp_pkg.
`timescale 1ns / 1ps

module gclp_dp (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [7:0]                   req_tdata,
   input  logic                         req_tlast,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [gclp_pkg::RSP_W-1:0]   rsp_tdata,
   input  gclp_pkg::cmd_type            cmd,
   output gclp_pkg::status_type         sts
);

   logic [7:0]            char_ff;
   logic                  last_ff;
   logic [7:0]            xor_ff;
   gclp_pkg::phase_type   phase_ff, phase_in;
   gclp_pkg::nstage_type  stage_ff, stage_in;
   logic [3:0]            active_ff, active_in;
   logic [63:0]           accum_ff, accum_in;
   logic [3:0]            frac_ff, frac_in;
   logic                  neg_ff, neg_in;
   logic [7:0]            chk_ff, chk_in;
   logic [12:0]           flags_ff, flags_in;

   logic [7:0]            val_g_ff, val_t_ff;
   logic [15:0]           val_m_ff;
   logic [31:0]           val_s_ff, val_p_ff;
   logic [31:0]           val_fx_ff [5];
   logic [63:0]           val_n_ff;

   logic [gclp_pkg::DIV_W-1:0]  num_ff;
   logic [30:0]                 rem_ff;
   logic [gclp_pkg::P10_W-1:0]  div_ff;
   logic [31:0]                 quot_ff;
   logic                        sticky_ff;
   logic [gclp_pkg::DCNT_W-1:0] cnt_ff;

   logic                        rsp_valid_ff;
   logic [gclp_pkg::RSP_W-1:0]  rsp_data_ff;

   // ---------------- number feed ----------------
   logic [7:0]  c;
   logic [7:0]  lc;
   logic [3:0]  dig;
   logic        blank, digit, sign_c, is_fixed, as_sign, feed_ok, num_valid;
   logic [67:0] acc_wide;
   logic [63:0] acc_next;
   gclp_pkg::nstage_type f_stage;
   logic        f_neg;
   logic [63:0] f_accum;
   logic [3:0]  f_frac;

   assign c      = char_ff;
   assign lc     = (c >= 8'h41 && c <= 8'h5A) ? 8'(c + 8'd32) : c;
   assign dig    = 4'(c - gclp_pkg::CH_ZERO);
   assign blank  = gclp_pkg::is_blank(c);
   assign digit  = gclp_pkg::is_digit(c);
   assign sign_c = (c == gclp_pkg::CH_PLUS) || (c == gclp_pkg::CH_MINUS);
   assign is_fixed = (active_ff >= gclp_pkg::F_X) && (active_ff <= gclp_pkg::F_E);
   assign num_valid = (stage_ff == gclp_pkg::ST_INT) || (stage_ff == gclp_pkg::ST_FRAC);

   // accum * 10 + digit, saturating at all ones
   assign acc_wide = {accum_ff, 3'b000} + {3'b000, accum_ff, 1'b0} + {64'd0, dig};
   assign acc_next = (acc_wide[67:64] != 4'd0) ? '1 : acc_wide[63:0];

   always_comb begin
      feed_ok = 1'b0;
      as_sign = 1'b0;
      f_stage = stage_ff;
      f_neg   = neg_ff;
      f_accum = accum_ff;
      f_frac  = frac_ff;
      case (stage_ff)
         gclp_pkg::ST_PRE: begin
            if (blank) feed_ok = 1'b1;
            else if (sign_c) begin
               feed_ok = 1'b1;
               f_neg = (c == gclp_pkg::CH_MINUS);
               f_stage = gclp_pkg::ST_SIGN;
            end else as_sign = 1'b1;
         end
         gclp_pkg::ST_SIGN: as_sign = 1'b1;
         gclp_pkg::ST_INT: begin
            if (digit) begin
               feed_ok = 1'b1;
               f_accum = acc_next;
            end else if (c == gclp_pkg::CH_DOT && is_fixed) begin
               feed_ok = 1'b1;
               f_stage = gclp_pkg::ST_FRAC;
            end
         end
         gclp_pkg::ST_DOT, gclp_pkg::ST_FRAC: begin
            if (digit) begin
               feed_ok = 1'b1;
               f_stage = gclp_pkg::ST_FRAC;
               if (frac_ff < 4'(gclp_pkg::MAX_FRAC)) begin
                  f_accum = acc_next;
                  f_frac = 4'(frac_ff + 4'd1);
               end
            end
         end
         default: feed_ok = 1'b0;
      endcase
      if (as_sign) begin
         if (digit) begin
            feed_ok = 1'b1;
            f_accum = acc_next;
            f_stage = gclp_pkg::ST_INT;
         end else if (c == gclp_pkg::CH_DOT && is_fixed) begin
            feed_ok = 1'b1;
            f_stage = gclp_pkg::ST_DOT;
         end
      end
   end

   // ---------------- integer field finish ----------------
   logic [63:0] int_val;
   always_comb begin
      case (active_ff)
         gclp_pkg::F_S, gclp_pkg::F_P:
            int_val = {32'd0, gclp_pkg::sat_s32(accum_ff, neg_ff)};
         gclp_pkg::F_G, gclp_pkg::F_T:
            int_val = neg_ff ? 64'd0 : (accum_ff > 64'hFF ? 64'hFF : accum_ff);
         gclp_pkg::F_M:
            int_val = neg_ff ? 64'd0 : (accum_ff > 64'hFFFF ? 64'hFFFF : accum_ff);
         default:
            int_val = neg_ff ? 64'd0 : accum_ff;
      endcase
   end

   // ---------------- divider ----------------
   logic [31:0]                r2;
   logic                       ge;
   logic [gclp_pkg::P10_W-1:0] p10;
   logic [31:0]                quot_nx;
   logic                       sticky_nx;
   logic [31:0]                fx_mag;
   logic [31:0]                fx_val;
   logic                       div_last;

   assign p10 = gclp_pkg::pow10(frac_ff);
   assign r2  = {rem_ff, num_ff[gclp_pkg::DIV_W-1]};
   assign ge  = r2 >= {2'b00, div_ff};
   assign div_last = (cnt_ff == gclp_pkg::DCNT_W'(gclp_pkg::DIV_W - 1));
   assign quot_nx   = {quot_ff[30:0], ge};
   assign sticky_nx = sticky_ff | quot_ff[31];
   // magnitude caps at 2^31 before sign and saturation; taken after the last step
   assign fx_mag = (sticky_nx || quot_nx[31]) ? 32'h8000_0000 : quot_nx;
   assign fx_val = gclp_pkg::sat_s32({32'd0, fx_mag}, neg_ff);

   // ---------------- per-character step ----------------
   logic       do_rest, do_finish, start_chk;
   logic [3:0] li;
   assign li = gclp_pkg::letter_index(lc);

   always_comb begin
      phase_in  = phase_ff;
      stage_in  = stage_ff;
      active_in = active_ff;
      accum_in  = accum_ff;
      frac_in   = frac_ff;
      neg_in    = neg_ff;
      chk_in    = chk_ff;
      flags_in  = flags_ff;
      do_rest   = 1'b0;
      do_finish = 1'b0;
      start_chk = 1'b0;
      case (phase_ff)
         gclp_pkg::PH_START: begin
            if (blank) phase_in = phase_ff;
            else if (c == gclp_pkg::CH_SEMI || c == gclp_pkg::CH_NL ||
                     c == gclp_pkg::CH_STAR) phase_in = gclp_pkg::PH_IGNORE;
            else if (c == gclp_pkg::CH_AT) phase_in = gclp_pkg::PH_HOST;
            else begin
               phase_in = gclp_pkg::PH_FIELDS;
               do_rest = 1'b1;
            end
         end
         gclp_pkg::PH_FIELDS: begin
            if (active_ff != gclp_pkg::F_NONE && feed_ok) begin
               stage_in = f_stage;
               neg_in   = f_neg;
               accum_in = f_accum;
               frac_in  = f_frac;
            end else begin
               do_finish = (active_ff != gclp_pkg::F_NONE);
               do_rest = 1'b1;
            end
         end
         gclp_pkg::PH_HOST: begin
            if (c == gclp_pkg::CH_SEMI || c == gclp_pkg::CH_NL || c == gclp_pkg::CH_STAR)
               phase_in = gclp_pkg::PH_IGNORE;
            else if (!blank) flags_in[gclp_pkg::HOST_BIT] = 1'b1;
         end
         gclp_pkg::PH_SEEK: begin
            if (c == gclp_pkg::CH_STAR) start_chk = 1'b1;
         end
         gclp_pkg::PH_CHECK: begin
            case (stage_ff)
               gclp_pkg::ST_PRE: begin
                  if (blank) stage_in = stage_ff;
                  else if (sign_c) begin
                     neg_in = (c == gclp_pkg::CH_MINUS);
                     stage_in = gclp_pkg::ST_SIGN;
                  end else if (digit) begin
                     chk_in = {4'd0, dig};
                     stage_in = gclp_pkg::ST_INT;
                  end else stage_in = gclp_pkg::ST_BAD;
               end
               gclp_pkg::ST_SIGN: begin
                  if (digit) begin
                     chk_in = {4'd0, dig};
                     stage_in = gclp_pkg::ST_INT;
                  end else stage_in = gclp_pkg::ST_BAD;
               end
               gclp_pkg::ST_INT: begin
                  if (digit) chk_in = 8'({chk_ff, 3'b000} + {chk_ff, 1'b0} + {7'd0, dig});
                  else stage_in = gclp_pkg::ST_OK;
               end
               default: stage_in = stage_ff;
            endcase
         end
         default: phase_in = phase_ff;
      endcase

      if (do_finish) begin
         // fixed fields with a number never get here: they go through the divider
         if (num_valid && !is_fixed) flags_in[active_ff] = 1'b1;
         active_in = gclp_pkg::F_NONE;
      end
      if (do_rest) begin
         if (c == gclp_pkg::CH_SEMI || c == gclp_pkg::CH_NL) phase_in = gclp_pkg::PH_SEEK;
         else if (c == gclp_pkg::CH_STAR) start_chk = 1'b1;
         else if (li != gclp_pkg::F_NONE && !flags_in[li]) begin
            active_in = li;
            stage_in  = gclp_pkg::ST_PRE;
            accum_in  = '0;
            frac_in   = '0;
            neg_in    = 1'b0;
         end
      end
      if (start_chk) begin
         phase_in = gclp_pkg::PH_CHECK;
         stage_in = gclp_pkg::ST_PRE;
         chk_in   = '0;
         neg_in   = 1'b0;
      end
   end

   // ---------------- status ----------------
   logic fields_open;
   assign fields_open = (phase_ff == gclp_pkg::PH_FIELDS) && (active_ff != gclp_pkg::F_NONE);

   assign sts.last          = last_ff;
   assign sts.need_div_exec = fields_open && !feed_ok && is_fixed && num_valid;
   assign sts.need_div_fin  = fields_open && is_fixed && num_valid;
   assign sts.fin_pending   = fields_open;
   assign sts.div_last      = div_last;
   assign sts.rsp_free      = !rsp_valid_ff || rsp_tready;

   // ---------------- line state registers ----------------
   logic int_wr;
   assign int_wr = (cmd.exec && do_finish && num_valid && !is_fixed) ||
                   (cmd.fin_field && num_valid && !is_fixed);

   always_ff @(posedge clock) begin
      if (reset || cmd.emit) begin
         xor_ff    <= '0;
         phase_ff  <= gclp_pkg::PH_START;
         stage_ff  <= gclp_pkg::ST_PRE;
         active_ff <= gclp_pkg::F_NONE;
         accum_ff  <= '0;
         frac_ff   <= '0;
         neg_ff    <= 1'b0;
         chk_ff    <= '0;
         flags_ff  <= '0;
      end else if (cmd.load) begin
         if (phase_ff != gclp_pkg::PH_CHECK && req_tdata != gclp_pkg::CH_STAR)
            xor_ff <= xor_ff ^ req_tdata;
      end else if (cmd.exec) begin
         phase_ff  <= phase_in;
         stage_ff  <= stage_in;
         active_ff <= active_in;
         accum_ff  <= accum_in;
         frac_ff   <= frac_in;
         neg_ff    <= neg_in;
         chk_ff    <= chk_in;
         flags_ff  <= flags_in;
      end else if (cmd.div_run && div_last) begin
         flags_ff[active_ff] <= 1'b1;
         active_ff <= gclp_pkg::F_NONE;
      end else if (cmd.fin_field) begin
         if (num_valid && !is_fixed) flags_ff[active_ff] <= 1'b1;
         active_ff <= gclp_pkg::F_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         char_ff <= req_tdata;
         last_ff <= req_tlast;
      end
   end

   // ---------------- value store ----------------
   always_ff @(posedge clock) begin
      if (int_wr) begin
         case (active_ff)
            gclp_pkg::F_G: val_g_ff <= int_val[7:0];
            gclp_pkg::F_M: val_m_ff <= int_val[15:0];
            gclp_pkg::F_T: val_t_ff <= int_val[7:0];
            gclp_pkg::F_S: val_s_ff <= int_val[31:0];
            gclp_pkg::F_P: val_p_ff <= int_val[31:0];
            default:       val_n_ff <= int_val;
         endcase
      end
      if (cmd.div_run && div_last)
         val_fx_ff[3'(active_ff - gclp_pkg::F_X)] <= fx_val;
   end

   // ---------------- divider registers ----------------
   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         num_ff    <= {1'b0, accum_ff, gclp_pkg::FRAC_BITS'(0)} +
                      gclp_pkg::DIV_W'(p10 >> 1);
         div_ff    <= p10;
         rem_ff    <= '0;
         quot_ff   <= '0;
         sticky_ff <= 1'b0;
         cnt_ff    <= '0;
      end else if (cmd.div_run) begin
         num_ff    <= {num_ff[gclp_pkg::DIV_W-2:0], 1'b0};
         rem_ff    <= ge ? 31'(r2 - {2'b00, div_ff}) : r2[30:0];
         quot_ff   <= quot_nx;
         sticky_ff <= sticky_nx;
         cnt_ff    <= gclp_pkg::DCNT_W'(cnt_ff + 1'b1);
      end
   end

   // ---------------- result register ----------------
   logic [12:0] out_flags;
   logic        chk_ok;
   logic [7:0]  chk_signed;

   assign chk_signed = neg_ff ? 8'(~chk_ff + 8'd1) : chk_ff;
   assign chk_ok = (phase_ff == gclp_pkg::PH_CHECK) &&
                   (stage_ff == gclp_pkg::ST_INT || stage_ff == gclp_pkg::ST_OK) &&
                   (chk_signed == xor_ff);

   always_comb begin
      out_flags = flags_ff;
      out_flags[gclp_pkg::CHECK_BIT] = chk_ok;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.emit) rsp_valid_ff <= 1'b1;
      else if (rsp_tready) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_data_ff <= gclp_pkg::RSP_W'({
            flags_ff[gclp_pkg::F_N] ? val_n_ff     : 64'd0,
            flags_ff[gclp_pkg::F_E] ? val_fx_ff[4] : 32'd0,
            flags_ff[gclp_pkg::F_F] ? val_fx_ff[3] : 32'd0,
            flags_ff[gclp_pkg::F_Z] ? val_fx_ff[2] : 32'd0,
            flags_ff[gclp_pkg::F_Y] ? val_fx_ff[1] : 32'd0,
            flags_ff[gclp_pkg::F_X] ? val_fx_ff[0] : 32'd0,
            flags_ff[gclp_pkg::F_P] ? val_p_ff     : 32'd0,
            flags_ff[gclp_pkg::F_S] ? val_s_ff     : 32'd0,
            flags_ff[gclp_pkg::F_T] ? val_t_ff     : 8'd0,
            flags_ff[gclp_pkg::F_M] ? val_m_ff     : 16'd0,
            flags_ff[gclp_pkg::F_G] ? val_g_ff     : 8'd0,
            out_flags});
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

@@ hw/rtl/gcode_line_parser.sv @@
// Top level of the G-code line parser: joins the sequencer and the datapath.
// Depends on gclp_pkg, gclp_ctrl and gclp_dp.
`timescale 1ns / 1ps

// Takes one character per beat on req_ and emits one result beat on rsp_
// after the beat marked req_tlast. An ordinary character is accepted and then
// takes one step of the line parser. A character that closes a number on X,
// Y, Z, F or E, and the end of a line with such a number still open, also go
// through the bit-serial divider (64 + fraction bits + 1 dividend bits) that
// converts the decimal fraction to fixed point before the work resumes. The
// end of a line adds a wrap-up, which also waits for the previous result to
// leave. The result sits in an output register, so the next line's
// characters are accepted while it waits on rsp_tready.

module gcode_line_parser (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [7:0]                 req_tdata,   // [7:0] char_byte
   input  logic                       req_tlast,   // line_last
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // [12:0] present_flags, [20:13] value_g, [36:21] value_m, [44:37] value_t,
   // [76:45] value_s, [108:77] value_p, [140:109] value_x, [172:141] value_y,
   // [204:173] value_z, [236:205] value_f, [268:237] value_e,
   // [332:269] value_n, [335:333] zero
   output logic [gclp_pkg::RSP_W-1:0] rsp_tdata
);

   gclp_pkg::cmd_type    cmd;
   gclp_pkg::status_type sts;

   gclp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   gclp_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule

@@ bench/gcode_line_parser_tb.sv @@
// Self-checking bench for gcode_line_parser: streams command lines character by character
// and compares each result beat against a line-parser predictor kept in a scoreboard class.
// Depends on gclp_pkg and the gcode_line_parser RTL.
`timescale 1ns / 1ps

module gcode_line_parser_tb;
   import gclp_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 200;

   class line_scoreboard;
      bit [RSP_W-1:0] lines_due[$];
      int             errors;
      bit [12:0]      flags;
      bit [63:0]      vals[NUM_PARAMS];
      bit [3:0]       fld;
      bit [63:0]      acc;
      int             fdig;
      bit             neg;
      phase_type      ph;
      nstage_type     ns;
      bit [7:0]       xr;
      bit [7:0]       cks;

      function new();
         errors = 0;
         clear();
      endfunction

      function void clear();
         flags = 0;
         foreach (vals[i]) vals[i] = 0;
         fld = F_NONE; acc = 0; fdig = 0; neg = 0;
         ph = PH_START; ns = ST_PRE; xr = 0; cks = 0;
      endfunction

      function bit blank(bit [7:0] c);
         return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
      endfunction

      function bit digit(bit [7:0] c);
         return c >= CH_ZERO && c <= 8'h39;
      endfunction

      function bit is_fixed(bit [3:0] f);
         return f >= F_X && f <= F_E;
      endfunction

      function bit [63:0] fmask(bit [3:0] f);
         if (f == F_G || f == F_T) return 64'hFF;
         if (f == F_M) return 64'hFFFF;
         if (f == F_N) return '1;
         return 64'hFFFF_FFFF;
      endfunction

      function void add_digit(bit [7:0] c);
         bit [63:0] d;
         d = 64'(c - CH_ZERO);
         if (acc > (64'hFFFF_FFFF_FFFF_FFFF - d) / 10) acc = '1;
         else acc = acc * 10 + d;
      endfunction

      function bit [63:0] clamp32(bit [63:0] mag, bit n);
         if (n) begin
            if (mag >= 64'h8000_0000) return 64'h8000_0000;
            return (64'd0 - mag) & 64'hFFFF_FFFF;
         end
         return mag > 64'h7FFF_FFFF ? 64'h7FFF_FFFF : mag;
      endfunction

      function bit [63:0] to_q16();
         bit [63:0] dv, ip, fr, mag;
         dv = 1;
         for (int i = 0; i < fdig && i < MAX_FRAC; i++) dv = dv * 10;
         ip = acc / dv;
         fr = acc % dv;
         if (ip >= (64'd1 << (31 - FRAC_BITS))) mag = 64'h8000_0000;
         else mag = (ip << FRAC_BITS) + ((fr << FRAC_BITS) + dv / 2) / dv;
         return clamp32(mag, neg);
      endfunction

      function void close_field();
         bit [63:0] v;
         if (fld < NUM_PARAMS && (ns == ST_INT || ns == ST_FRAC)) begin
            v = acc;
            if (fld == F_S || fld == F_P) v = clamp32(v, neg);
            else if (is_fixed(fld)) v = to_q16();
            else if (neg) v = 0;
            else if (v > fmask(fld)) v = fmask(fld);
            vals[fld] = v & fmask(fld);
            flags[fld] = 1'b1;
         end
         fld = F_NONE;
      endfunction

      // returns 1 when the character belongs to the number in progress
      function bit number_char(bit [7:0] c);
         bit fx;
         fx = is_fixed(fld);
         if (ns == ST_PRE && blank(c)) return 1;
         if (ns == ST_PRE && (c == CH_PLUS || c == CH_MINUS)) begin
            neg = (c == CH_MINUS); ns = ST_SIGN; return 1;
         end
         case (ns)
            ST_PRE, ST_SIGN: begin
               if (digit(c)) begin add_digit(c); ns = ST_INT; return 1; end
               if (c == CH_DOT && fx) begin ns = ST_DOT; return 1; end
               return 0;
            end
            ST_INT: begin
               if (digit(c)) begin add_digit(c); return 1; end
               if (c == CH_DOT && fx) begin ns = ST_FRAC; return 1; end
               return 0;
            end
            ST_DOT, ST_FRAC: begin
               if (!digit(c)) return 0;
               if (fdig < MAX_FRAC) begin add_digit(c); fdig++; end
               ns = ST_FRAC;
               return 1;
            end
            default: return 0;
         endcase
      endfunction

      function void begin_check();
         ph = PH_CHECK; ns = ST_PRE; cks = 0; neg = 0;
      endfunction

      function void field_char(bit [7:0] c);
         bit [7:0] lc;
         bit [3:0] idx;
         lc = (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
         if (fld != F_NONE) begin
            if (number_char(c)) return;
            close_field();
         end
         if (c == CH_SEMI || c == CH_NL) begin ph = PH_SEEK; return; end
         if (c == CH_STAR) begin begin_check(); return; end
         case (lc)
            8'h67: idx = F_G;  8'h6D: idx = F_M;  8'h74: idx = F_T;
            8'h73: idx = F_S;  8'h70: idx = F_P;  8'h78: idx = F_X;
            8'h79: idx = F_Y;  8'h7A: idx = F_Z;  8'h66: idx = F_F;
            8'h65: idx = F_E;  8'h6E: idx = F_N;  default: idx = F_NONE;
         endcase
         if (idx != F_NONE && !flags[idx]) begin
            fld = idx; ns = ST_PRE; acc = 0; fdig = 0; neg = 0;
         end
      endfunction

      function void check_char(bit [7:0] c);
         if (ns == ST_PRE && blank(c)) return;
         if (ns == ST_PRE && (c == CH_PLUS || c == CH_MINUS)) begin
            neg = (c == CH_MINUS); ns = ST_SIGN; return;
         end
         case (ns)
            ST_PRE, ST_SIGN: begin
               if (digit(c)) begin cks = c - CH_ZERO; ns = ST_INT; end
               else ns = ST_BAD;
            end
            ST_INT: begin
               if (digit(c)) cks = cks * 8'd10 + (c - CH_ZERO);
               else ns = ST_OK;
            end
            default: ;
         endcase
      endfunction

      // one accepted character beat
      function void note(bit [7:0] c, bit last);
         bit [12:0] f;
         bit [7:0]  g;
         bit [63:0] v[NUM_PARAMS];
         if (ph != PH_CHECK && c != CH_STAR) xr ^= c;
         case (ph)
            PH_START: begin
               if (!blank(c)) begin
                  if (c == CH_SEMI || c == CH_NL || c == CH_STAR) ph = PH_IGNORE;
                  else if (c == CH_AT) ph = PH_HOST;
                  else begin ph = PH_FIELDS; field_char(c); end
               end
            end
            PH_FIELDS: field_char(c);
            PH_HOST: begin
               if (c == CH_SEMI || c == CH_NL || c == CH_STAR) ph = PH_IGNORE;
               else if (!blank(c)) flags[HOST_BIT] = 1'b1;
            end
            PH_SEEK: if (c == CH_STAR) begin_check();
            PH_CHECK: check_char(c);
            default: ;
         endcase
         if (!last) return;
         if (ph == PH_FIELDS && fld != F_NONE) close_field();
         f = flags;
         if (ph == PH_CHECK && (ns == ST_INT || ns == ST_OK)) begin
            g = neg ? 8'd0 - cks : cks;
            if (g == xr) f[CHECK_BIT] = 1'b1;
         end
         foreach (v[i]) v[i] = f[i] ? vals[i] & fmask(i) : 64'd0;
         lines_due.push_back({3'b000, v[10], v[9][31:0], v[8][31:0], v[7][31:0],
                              v[6][31:0], v[5][31:0], v[4][31:0], v[3][31:0],
                              v[2][7:0], v[1][15:0], v[0][7:0], f});
         clear();
      endfunction

      function bit [63:0] slice(bit [RSP_W-1:0] r, int lo, int w);
         bit [63:0] s;
         s = 64'(r >> lo);
         if (w < 64) s &= (64'd1 << w) - 1;
         return s;
      endfunction

      function void check(bit [RSP_W-1:0] got);
         bit [RSP_W-1:0] want;
         string names[12] = '{"present_flags", "value_g", "value_m", "value_t", "value_s",
                              "value_p", "value_x", "value_y", "value_z", "value_f",
                              "value_e", "value_n"};
         int widths[12] = '{13, 8, 16, 8, 32, 32, 32, 32, 32, 32, 32, 64};
         int lo;
         if (lines_due.size() == 0) begin
            $error("result beat with no line pending: %h", got);
            errors++;
            return;
         end
         want = lines_due.pop_front();
         lo = 0;
         for (int i = 0; i < 12; i++) begin
            if (slice(want, lo, widths[i]) != slice(got, lo, widths[i])) begin
               $error("%s: expected %h, got %h", names[i],
                      slice(want, lo, widths[i]), slice(got, lo, widths[i]));
               errors++;
            end
            lo += widths[i];
         end
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [7:0]       req_tdata;
   logic             req_tlast;
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [RSP_W-1:0] rsp_tdata;

   line_scoreboard sb;
   int             idle_pct;
   int             stall_pct;
   int             hold_cycles;
   int             quiet_cycles;
   int             chars_sent;

   gcode_line_parser uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver: random stalls, plus a counted hold-off when requested
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_tready  <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check(rsp_tdata);
      if (reset || (rsp_tvalid && rsp_tready) || (req_tvalid && req_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic send_char(bit [7:0] c, bit last);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      sb.note(c, last);
      chars_sent++;
      @(negedge clock);
   endtask

   // valid stays up after the last beat; the next beat replaces it or drops it to idle, and wait_drained drops it
   task automatic send_line(bit [7:0] q[$]);
      foreach (q[i]) send_char(q[i], i == q.size() - 1);
   endtask

   task automatic send_text(string s);
      bit [7:0] q[$];
      for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
      send_line(q);
   endtask

   task automatic put_str(ref bit [7:0] q[$], ref bit [7:0] x, input string s);
      for (int i = 0; i < s.len(); i++) begin
         q.push_back(s[i]);
         x ^= s[i];
      end
   endtask

   task automatic put_digits(ref bit [7:0] q[$], ref bit [7:0] x, input int n);
      bit [7:0] d;
      for (int i = 0; i < n; i++) begin
         d = CH_ZERO + 8'($urandom_range(9));
         q.push_back(d);
         x ^= d;
      end
   endtask

   // mostly well-formed command lines with random content, some host lines and noise
   task automatic random_line();
      bit [7:0] q[$];
      bit [7:0] x;
      bit [7:0] ch;
      string    letters;
      string    sym;
      int       kind;
      int       np;
      kind = $urandom_range(99);
      x = 0;
      letters = "gmtspxyzfenGMTSPXYZFEN";
      if (kind < 8) begin
         for (int i = 0; i < $urandom_range(12, 1); i++) q.push_back(8'($urandom));
      end else if (kind < 16) begin
         put_str(q, x, $urandom_range(1) ? "@" : " @");
         if ($urandom_range(3) != 0) put_str(q, x, "pause");
         if ($urandom_range(1)) put_str(q, x, ";x");
      end else begin
         if ($urandom_range(3) == 0) put_str(q, x, " ");
         np = $urandom_range(5, 1);
         for (int p = 0; p < np; p++) begin
            ch = letters[$urandom_range(letters.len() - 1)];
            q.push_back(ch);
            x ^= ch;
            if ($urandom_range(4) == 0) put_str(q, x, " ");
            case ($urandom_range(5))
               0: put_str(q, x, "-");
               1: put_str(q, x, "+");
               default: ;
            endcase
            put_digits(q, x, $urandom_range(19) == 0 ? $urandom_range(24, 8)
                                                     : $urandom_range(5, 0));
            if ($urandom_range(2) == 0) begin
               put_str(q, x, ".");
               put_digits(q, x, $urandom_range(9) == 0 ? $urandom_range(13, 8)
                                                       : $urandom_range(4));
            end
            if ($urandom_range(5) == 0) put_str(q, x, " ");
            if ($urandom_range(29) == 0) put_str(q, x, "e3");
         end
         if ($urandom_range(2) == 0) put_str(q, x, ";note");
         if ($urandom_range(3) != 0) begin
            q.push_back(CH_STAR);
            if ($urandom_range(4) == 0) x = 8'($urandom);
            if ($urandom_range(5) == 0) begin
               q.push_back(CH_MINUS);
               x = 8'd0 - x;
            end
            sym = $sformatf("%0d", x);
            for (int i = 0; i < sym.len(); i++) q.push_back(sym[i]);
         end
         if ($urandom_range(1)) q.push_back(CH_NL);
      end
      send_line(q);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (sb.lines_due.size() != 0) @(posedge clock);
   endtask

   initial begin
      bit [7:0] q[$];
      sb          = new();
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = 8'd0;
      req_tlast   = 1'b0;
      rsp_tready  = 1'b0;
      idle_pct    = 0;
      stall_pct   = 0;
      hold_cycles = 0;
      chars_sent  = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed lines
      send_text("G1 X-12.5 Y.25 Z0.0000152587890625 F3000 E-0.5*");
      send_text("N123 g28 m104 s-5 p+7 t3 *41\n");
      send_text("M99999 G300 T256 N99999999999999999999999 S3000000000 P-3000000000");
      send_text("X32767.99999 Y-32768 Z40000 F-40000 E1.123456789123");
      send_text("G1 G2 X5 X7 m- M4 x1e5");
      send_text("   \t;comment only");
      send_text(" ");
      send_text("\n");
      send_text("*12");
      send_text("@");
      send_text(" @host text*5");
      send_text("G1*-12 trailing");
      send_text("G1*");
      send_text("M105 ;x*z");
      send_text("G0 x - 5 Y. Z-.5");
      q = '{8'h47, 8'h00, 8'h31, 8'h80, 8'hFF, 8'h58, 8'h33};
      send_line(q);
      send_text("S-0 P-2147483648 E+.5");
      wait_drained();

      // random part, four phases of source idling and receiver stalls
      for (int ph = 0; ph < 4; ph++) begin
         idle_pct  = (ph == 1 || ph == 3) ? (ph == 1 ? 54 : 36) : 0;
         stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 54 : 36) : 0;
         if (ph == 1) hold_cycles = 600;
         while (chars_sent < 180 * (ph + 1) + 330) random_line();
      end
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.lines_due.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
